// ===== sv/gsa_pkg.sv =====
// Shared types and constants for the generational slot allocator.
// Used by generational_slot_allocator, gsa_chk and the testbench; no dependencies.
package gsa_pkg;

  // Default number of slots
  localparam int SLOTS_DEF = 1024;

  // Fixed field widths
  localparam int KIND_W    = 2;
  localparam int HIDX_W    = 16;
  localparam int GEN_W     = 16;
  localparam int OUT_IDX_W = 10;

  // Only this kind tag names a slot handle
  localparam logic [KIND_W-1:0] KIND_SLOT = 2'd1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2,
    OP_RSVD    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_STK,
    S_GEN
  } state_t;

endpackage

// ===== sv/gsa_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Holds the generation table and the free stack; no package dependencies.
module gsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/generational_slot_allocator.sv =====
// Top level of the generational slot allocator: request sequencer around two RAMs.
// Depends on gsa_pkg and gsa_ram.
//
//  channel   handshake          fields
//  -------   ----------------   -----------------------------------------------
//  request   start / busy       opcode, handle_kind, handle_index, handle_generation
//  result    done (1 cycle)     status, slot_index, slot_generation
//
// One request at a time. done is registered from the last state: DECIDE for a fresh
// allocate, a full table, a reserved opcode or a handle rejected on its fields; DECIDE then
// GEN for a release or check that reads the table; DECIDE, STK and GEN for a popped allocate.
// A new request is taken at the edge that ends the done cycle.
// Reset is synchronous and needs no clearing pass: table entries at or above the fresh
// count read as zero. The receiver cannot stall; done lasts exactly one cycle.
module generational_slot_allocator #(
  parameter int SLOTS = gsa_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [gsa_pkg::KIND_W-1:0]     handle_kind,
  input  logic [gsa_pkg::HIDX_W-1:0]     handle_index,
  input  logic [gsa_pkg::GEN_W-1:0]      handle_generation,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [gsa_pkg::OUT_IDX_W-1:0]  slot_index,
  output logic [gsa_pkg::GEN_W-1:0]      slot_generation
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = CW + 1;
  localparam int XW = (LW > gsa_pkg::HIDX_W + 1) ? LW : gsa_pkg::HIDX_W + 1;
  localparam int GW = gsa_pkg::GEN_W;

  gsa_pkg::state_t state, state_next;

  // Latched request
  gsa_pkg::opcode_t         req_op;
  logic [gsa_pkg::KIND_W-1:0] req_kind;
  logic [gsa_pkg::HIDX_W-1:0] req_index;
  logic [GW-1:0]            req_gen;

  // Slot under work and counters
  logic [IW-1:0] slot, slot_next;
  logic [CW-1:0] fresh_count, fresh_count_next;
  logic [CW-1:0] free_depth, free_depth_next;

  // Result staging
  logic          done_next;
  logic [1:0]    status_next;
  logic [gsa_pkg::OUT_IDX_W-1:0] slot_index_next;
  logic [GW-1:0] slot_generation_next;

  // RAM ports
  logic          tbl_we;
  logic [IW-1:0] tbl_waddr, tbl_raddr;
  logic [GW-1:0] tbl_wdata, tbl_rdata;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr, stk_rdata;

  // Decode helpers
  logic          accept;
  logic          fields_ok;
  logic          take_fresh;
  logic [XW-1:0] fresh_plus1;
  logic [GW-1:0] stored_gen;
  logic [GW-1:0] bumped_gen;
  logic [GW-1:0] alloc_gen;

  gsa_ram #(.WIDTH(GW), .DEPTH(SLOTS)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  gsa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (slot),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign busy   = rst || (state != gsa_pkg::S_IDLE);
  assign accept = start && !busy;

  // Validate handle fields that need no table lookup
  assign fields_ok = (req_kind == gsa_pkg::KIND_SLOT) && (req_gen != '0) &&
                     (XW'(req_index) < XW'(SLOTS));

  // Fresh slot while short of the last one, or the last one once the stack is empty
  assign fresh_plus1 = XW'(fresh_count) + XW'(1);
  assign take_fresh  = (fresh_plus1 < XW'(SLOTS)) ||
                       ((free_depth == '0) && (fresh_count < CW'(SLOTS)));

  // Entries never handed out still hold stale data: read them as zero
  assign stored_gen = (CW'(slot) < fresh_count) ? tbl_rdata : '0;
  assign bumped_gen = (stored_gen + GW'(1) == '0) ? GW'(1) : stored_gen + GW'(1);
  assign alloc_gen  = (stored_gen == '0) ? GW'(1) : stored_gen;

  // Hold state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gsa_pkg::S_IDLE;
      fresh_count <= '0;
      free_depth  <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      fresh_count <= fresh_count_next;
      free_depth  <= free_depth_next;
      done        <= done_next;
    end
  end

  // Capture request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= gsa_pkg::opcode_t'(opcode);
      req_kind  <= handle_kind;
      req_index <= handle_index;
      req_gen   <= handle_generation;
    end
    slot            <= slot_next;
    status          <= status_next;
    slot_index      <= slot_index_next;
    slot_generation <= slot_generation_next;
  end

  // Sequence one request: decide, read stack, read table, write back
  always_comb begin
    state_next           = state;
    slot_next            = slot;
    fresh_count_next     = fresh_count;
    free_depth_next      = free_depth;
    done_next            = 1'b0;
    status_next          = status;
    slot_index_next      = slot_index;
    slot_generation_next = slot_generation;
    tbl_we               = 1'b0;
    tbl_waddr            = slot;
    tbl_wdata            = bumped_gen;
    tbl_raddr            = req_index[IW-1:0];
    stk_we               = 1'b0;
    stk_waddr            = free_depth[IW-1:0];
    stk_raddr            = free_depth[IW-1:0] - IW'(1);

    unique case (state)
      gsa_pkg::S_IDLE: begin
        if (accept) begin
          state_next = gsa_pkg::S_DECIDE;
        end
      end

      gsa_pkg::S_DECIDE: begin
        slot_next            = req_index[IW-1:0];
        slot_index_next      = '0;
        slot_generation_next = '0;
        state_next           = gsa_pkg::S_IDLE;
        unique case (req_op)
          gsa_pkg::OP_ALLOC: begin
            priority if (take_fresh) begin
              // Fresh slot always starts at generation 1
              tbl_we               = 1'b1;
              tbl_waddr            = fresh_count[IW-1:0];
              tbl_wdata            = GW'(1);
              fresh_count_next     = fresh_count + CW'(1);
              done_next            = 1'b1;
              status_next          = gsa_pkg::ST_OK;
              slot_index_next      = gsa_pkg::OUT_IDX_W'(fresh_count[IW-1:0]);
              slot_generation_next = GW'(1);
            end else if (free_depth != '0) begin
              free_depth_next = free_depth - CW'(1);
              state_next      = gsa_pkg::S_STK;
            end else begin
              done_next   = 1'b1;
              status_next = gsa_pkg::ST_FULL;
            end
          end
          gsa_pkg::OP_RELEASE, gsa_pkg::OP_CHECK: begin
            if (fields_ok) begin
              state_next = gsa_pkg::S_GEN;
            end else begin
              done_next   = 1'b1;
              status_next = gsa_pkg::ST_INVALID;
            end
          end
          default: begin
            done_next   = 1'b1;
            status_next = gsa_pkg::ST_INVALID;
          end
        endcase
      end

      gsa_pkg::S_STK: begin
        // Popped index goes straight to the table read
        slot_next  = stk_rdata;
        tbl_raddr  = stk_rdata;
        state_next = gsa_pkg::S_GEN;
      end

      gsa_pkg::S_GEN: begin
        done_next  = 1'b1;
        state_next = gsa_pkg::S_IDLE;
        unique case (req_op)
          gsa_pkg::OP_ALLOC: begin
            tbl_we               = 1'b1;
            tbl_wdata            = alloc_gen;
            status_next          = gsa_pkg::ST_OK;
            slot_index_next      = gsa_pkg::OUT_IDX_W'(slot);
            slot_generation_next = alloc_gen;
          end
          gsa_pkg::OP_RELEASE: begin
            if (stored_gen == req_gen) begin
              // Bump generation and push the index unless the stack is full
              tbl_we      = 1'b1;
              status_next = gsa_pkg::ST_OK;
              if (free_depth < CW'(SLOTS)) begin
                stk_we          = 1'b1;
                free_depth_next = free_depth + CW'(1);
              end
            end else begin
              status_next = gsa_pkg::ST_INVALID;
            end
          end
          gsa_pkg::OP_CHECK: begin
            status_next = (stored_gen == req_gen) ? gsa_pkg::ST_OK : gsa_pkg::ST_INVALID;
          end
          default: begin
            status_next = gsa_pkg::ST_INVALID;
          end
        endcase
      end

      default: begin
        state_next = gsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/gsa_chk.sv =====
// Port-level checks for the generational slot allocator, bound to the top level.
// Depends on gsa_pkg and generational_slot_allocator.
module gsa_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [1:0]                    status,
  input logic [gsa_pkg::OUT_IDX_W-1:0] slot_index,
  input logic [gsa_pkg::GEN_W-1:0]     slot_generation
);

  // An accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A result strobe ends the request, so no second strobe follows at once
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two consecutive cycles");

  // Results appear only once the block is ready again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Failed requests carry no slot
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == gsa_pkg::ST_FULL || status == gsa_pkg::ST_INVALID)
      |-> slot_index == '0 && slot_generation == '0)
    else $error("failed request returned a slot");

  // No stray result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

endmodule

bind generational_slot_allocator gsa_chk u_gsa_chk (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .status          (status),
  .slot_index      (slot_index),
  .slot_generation (slot_generation)
);

// ===== sim/testbench.sv =====
// Testbench for generational_slot_allocator: directed and random requests, each result
// checked against an in-bench model of the generation table, fresh count and free stack.
// Depends on gsa_pkg and the RTL of generational_slot_allocator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = gsa_pkg::SLOTS_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0]                    status;
    logic [gsa_pkg::OUT_IDX_W-1:0] index;
    logic [gsa_pkg::GEN_W-1:0]     gen;
  } slot_result_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [1:0]                    opcode;
  logic [gsa_pkg::KIND_W-1:0]    handle_kind;
  logic [gsa_pkg::HIDX_W-1:0]    handle_index;
  logic [gsa_pkg::GEN_W-1:0]     handle_generation;
  logic                          done;
  logic [1:0]                    status;
  logic [gsa_pkg::OUT_IDX_W-1:0] slot_index;
  logic [gsa_pkg::GEN_W-1:0]     slot_generation;

  // Allocator model state
  logic [gsa_pkg::GEN_W-1:0] gen_table [SLOTS];
  int unsigned               free_slots [SLOTS];
  int unsigned               fresh_cnt;
  int unsigned               free_cnt;

  // Handles currently held by the bench
  bit               slot_live [SLOTS];
  int unsigned      live_slots [$];

  slot_result_t     expected_results [$];
  slot_result_t     want;
  int               mismatches;
  bit               idle_on;

  generational_slot_allocator #(
    .SLOTS(SLOTS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .handle_kind      (handle_kind),
    .handle_index     (handle_index),
    .handle_generation(handle_generation),
    .done             (done),
    .status           (status),
    .slot_index       (slot_index),
    .slot_generation  (slot_generation)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run if results stop coming
  initial begin
    #500us;
    $display("generational_slot_allocator: mismatch");
    $finish;
  end

  function automatic bit handle_ok(input logic [gsa_pkg::KIND_W-1:0] kind,
                                   input logic [gsa_pkg::HIDX_W-1:0] idx,
                                   input logic [gsa_pkg::GEN_W-1:0] gen);
    if (kind != gsa_pkg::KIND_SLOT || gen == '0 || idx >= SLOTS)
      return 1'b0;
    return gen_table[idx] == gen;
  endfunction

  // Advance the model by one request and return the result it should give
  function automatic slot_result_t predict_request(input logic [1:0] op,
                                                   input logic [gsa_pkg::KIND_W-1:0] kind,
                                                   input logic [gsa_pkg::HIDX_W-1:0] idx,
                                                   input logic [gsa_pkg::GEN_W-1:0] gen);
    slot_result_t              r;
    int unsigned               slot;
    logic [gsa_pkg::GEN_W-1:0] g;
    r = '0;
    case (op)
      gsa_pkg::OP_ALLOC: begin
        // fresh first, keeping the last fresh slot until the stack runs dry
        if (fresh_cnt + 1 < SLOTS) begin
          slot = fresh_cnt;
          fresh_cnt++;
        end else if (free_cnt > 0) begin
          free_cnt--;
          slot = free_slots[free_cnt];
        end else if (fresh_cnt < SLOTS) begin
          slot = fresh_cnt;
          fresh_cnt++;
        end else begin
          r.status = gsa_pkg::ST_FULL;
          return r;
        end
        if (gen_table[slot] == '0)
          gen_table[slot] = gsa_pkg::GEN_W'(1);
        r.status = gsa_pkg::ST_OK;
        r.index  = slot[gsa_pkg::OUT_IDX_W-1:0];
        r.gen    = gen_table[slot];
      end
      gsa_pkg::OP_RELEASE: begin
        if (!handle_ok(kind, idx, gen)) begin
          r.status = gsa_pkg::ST_INVALID;
        end else begin
          // bump the generation, skipping zero; push only while the stack has room
          g = gen_table[idx] + 1'b1;
          if (g == '0)
            g = gsa_pkg::GEN_W'(1);
          gen_table[idx] = g;
          if (free_cnt < SLOTS) begin
            free_slots[free_cnt] = 32'(idx);
            free_cnt++;
          end
        end
      end
      gsa_pkg::OP_CHECK: begin
        if (!handle_ok(kind, idx, gen))
          r.status = gsa_pkg::ST_INVALID;
      end
      default: r.status = gsa_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  // Send one request, record its expected result and track held handles
  task automatic issue(input logic [1:0] op, input logic [gsa_pkg::KIND_W-1:0] kind,
                       input logic [gsa_pkg::HIDX_W-1:0] idx,
                       input logic [gsa_pkg::GEN_W-1:0] gen,
                       output slot_result_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    start             <= 1'b1;
    opcode            <= op;
    handle_kind       <= kind;
    handle_index      <= idx;
    handle_generation <= gen;
    // hold until the block takes the request
    @(posedge clk);
    while (busy) @(posedge clk);
    res = predict_request(op, kind, idx, gen);
    expected_results.push_back(res);
    if (op == gsa_pkg::OP_ALLOC && res.status == gsa_pkg::ST_OK && !slot_live[res.index]) begin
      slot_live[res.index] = 1'b1;
      live_slots.push_back(32'(res.index));
    end
    if (op == gsa_pkg::OP_RELEASE && res.status == gsa_pkg::ST_OK && slot_live[idx]) begin
      slot_live[idx] = 1'b0;
      for (int i = 0; i < live_slots.size(); i++) begin
        if (live_slots[i] == idx) begin
          live_slots.delete(i);
          break;
        end
      end
    end
    @(negedge clk);
  endtask

  // Allocate with random noise on the unused handle fields
  task automatic issue_alloc(output slot_result_t res);
    issue(gsa_pkg::OP_ALLOC, gsa_pkg::KIND_W'($urandom), gsa_pkg::HIDX_W'($urandom),
          gsa_pkg::GEN_W'($urandom), res);
  endtask

  // Use a handle the bench holds; allocate when none is held
  task automatic issue_live(input logic [1:0] op);
    slot_result_t res;
    int unsigned  slot;
    if (live_slots.size() == 0) begin
      issue_alloc(res);
    end else begin
      slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
      issue(op, gsa_pkg::KIND_SLOT, slot[gsa_pkg::HIDX_W-1:0], gen_table[slot], res);
    end
  endtask

  task automatic random_request();
    slot_result_t res;
    int unsigned  pick;
    int unsigned  slot;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      issue_alloc(res);
    end else if (pick < 55) begin
      issue_live(gsa_pkg::OP_RELEASE);
    end else if (pick < 70) begin
      issue_live(gsa_pkg::OP_CHECK);
    end else if (pick < 80) begin
      // current or off-by-one generation on an in-range slot
      slot = $urandom_range(0, SLOTS - 1);
      issue(2'($urandom_range(gsa_pkg::OP_RELEASE, gsa_pkg::OP_CHECK)), gsa_pkg::KIND_SLOT,
            slot[gsa_pkg::HIDX_W-1:0],
            gsa_pkg::GEN_W'(gen_table[slot] + $urandom_range(0, 2) - 1), res);
    end else if (pick < 95) begin
      issue(2'($urandom_range(gsa_pkg::OP_ALLOC, gsa_pkg::OP_RSVD)),
            gsa_pkg::KIND_W'($urandom), gsa_pkg::HIDX_W'($urandom),
            gsa_pkg::GEN_W'($urandom), res);
    end else begin
      issue(gsa_pkg::OP_RSVD, gsa_pkg::KIND_W'($urandom), gsa_pkg::HIDX_W'($urandom),
            gsa_pkg::GEN_W'($urandom), res);
    end
  endtask

  // Field extremes, every opcode and every way a handle can be rejected
  task automatic test_handle_rules();
    slot_result_t a;
    slot_result_t b;
    slot_result_t res;
    // nothing is valid in an empty table
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, 16'd0, 16'd1, res);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, 16'd0, 16'd0, res);
    issue(gsa_pkg::OP_ALLOC, 2'd0, 16'd0, 16'd0, a);
    issue(gsa_pkg::OP_ALLOC, 2'd3, 16'hFFFF, 16'hFFFF, b);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(a.index), a.gen, res);
    issue(gsa_pkg::OP_CHECK, 2'd0, gsa_pkg::HIDX_W'(a.index), a.gen, res);
    issue(gsa_pkg::OP_CHECK, 2'd2, gsa_pkg::HIDX_W'(a.index), a.gen, res);
    issue(gsa_pkg::OP_CHECK, 2'd3, gsa_pkg::HIDX_W'(a.index), a.gen, res);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(a.index), 16'd0, res);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(SLOTS), 16'd1, res);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, 16'hFFFF, 16'hFFFF, res);
    issue(gsa_pkg::OP_RELEASE, gsa_pkg::KIND_SLOT, 16'hFFFF, 16'd1, res);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(b.index),
          gsa_pkg::GEN_W'(b.gen + 1), res);
    issue(gsa_pkg::OP_RELEASE, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(a.index), a.gen, res);
    // the old handle is now stale
    issue(gsa_pkg::OP_RELEASE, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(a.index), a.gen, res);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(a.index), a.gen, res);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(a.index),
          gen_table[a.index], res);
    issue(gsa_pkg::OP_RELEASE, 2'd0, gsa_pkg::HIDX_W'(b.index), b.gen, res);
    issue(gsa_pkg::OP_RSVD, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(b.index), b.gen, res);
    issue(gsa_pkg::OP_RSVD, 2'd3, 16'hFFFF, 16'hFFFF, res);
    issue(gsa_pkg::OP_ALLOC, 2'd1, 16'h5A5A, 16'hA5A5, res);
    issue(gsa_pkg::OP_CHECK, gsa_pkg::KIND_SLOT, gsa_pkg::HIDX_W'(b.index), b.gen, res);
  endtask

  // Mostly well-formed handle traffic with noise; optionally no idling at the end
  task automatic test_random_traffic(input int count, input bit quiet_tail);
    for (int i = 0; i < count; i++) begin
      idle_on = !(quiet_tail && i >= count - count / 3);
      random_request();
    end
    idle_on = 1'b1;
  endtask

  // Exhaust fresh slots, the free stack and the last slot, then hit full
  task automatic test_fill_table();
    slot_result_t res;
    int           full_seen;
    full_seen = 0;
    while (full_seen < 3) begin
      if ($urandom_range(0, 15) == 0) begin
        issue_live(gsa_pkg::OP_CHECK);
      end else begin
        issue_alloc(res);
        if (res.status == gsa_pkg::ST_FULL)
          full_seen++;
      end
    end
    // free a few and take them back off the stack
    repeat (6) issue_live(gsa_pkg::OP_RELEASE);
    repeat (8) issue_alloc(res);
  endtask

  // Compare each result with the oldest expected one
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d index %0d generation %0d",
                   status, slot_index, slot_generation);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || slot_index !== want.index ||
            slot_generation !== want.gen) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("wrong result: expected status %0d index %0d generation %0d, got %0d %0d %0d",
                     want.status, want.index, want.gen, status, slot_index, slot_generation);
        end
      end
    end
  end

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    opcode            = gsa_pkg::OP_ALLOC;
    handle_kind       = '0;
    handle_index      = '0;
    handle_generation = '0;
    fresh_cnt         = 0;
    free_cnt          = 0;
    mismatches        = 0;
    idle_on           = 1'b1;
    foreach (gen_table[i]) gen_table[i] = '0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_handle_rules();
    test_random_traffic(50, 1'b0);
    test_fill_table();
    test_random_traffic(100, 1'b1);

    // drain outstanding results
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("generational_slot_allocator: match");
    end else begin
      $display("generational_slot_allocator: mismatch");
    end
    $finish;
  end

endmodule
